FILE: hw/rtl/hqr_pkg.sv
// Shared types, constants and saturation helpers for the QR decomposition core.
package hqr_pkg;

    localparam int MAX_SIZE  = 4;
    localparam int FRAC_BITS = 16;

    // command into the root/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_rd_cmd;

    // status back from the root/divide unit
    typedef struct packed {
        logic done;
    } t_rd_stat;

    function automatic logic signed [47:0] sat48(input logic signed [55:0] x);
        logic signed [55:0] hi;
        logic signed [55:0] lo;
        hi = 56'sh00_7FFF_FFFF_FFFF;
        lo = -56'sh00_8000_0000_0000;
        if (x > hi) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (x < lo) begin
            return 48'sh8000_0000_0000;
        end else begin
            return x[47:0];
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] x);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -48'sh0000_8000_0000;
        if (x > hi) begin
            return 32'h7FFF_FFFF;
        end else if (x < lo) begin
            return 32'h8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

FILE: hw/rtl/hqr_rootdiv.sv
// Bit-serial integer square root and restoring divider sharing one datapath.
module hqr_rootdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hqr_pkg::t_rd_cmd   i_cmd,
    input  logic [61:0]        i_opa,     // radicand, or dividend in the low 30 bits
    input  logic [30:0]        i_opb,     // divisor
    output hqr_pkg::t_rd_stat  o_stat,
    output logic [30:0]        o_result
);

    logic        r_busy;
    logic        r_div;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [62:0] r_acc;
    logic [62:0] r_aux;
    logic [62:0] r_bit;
    logic [30:0] r_quo;
    logic [62:0] trial;

    assign trial = r_div ? r_aux : (r_aux + r_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_cmd.start && r_busy && (r_cnt == 5'd0);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_div  <= i_cmd.is_div;
                r_cnt  <= 5'd30;
                r_quo  <= '0;
                r_bit  <= 63'(1) << 60;
                if (i_cmd.is_div) begin
                    r_acc <= 63'(i_opa[29:0]) << 30;
                    r_aux <= 63'(i_opb) << 30;
                end else begin
                    r_acc <= {1'b0, i_opa};
                    r_aux <= '0;
                end
            end else if (r_busy) begin
                // one root digit or one quotient bit per cycle
                if (r_acc >= trial) begin
                    r_acc <= r_acc - trial;
                    r_quo <= {r_quo[29:0], 1'b1};
                    r_aux <= r_div ? (r_aux >> 1) : ((r_aux >> 1) + r_bit);
                end else begin
                    r_quo <= {r_quo[29:0], 1'b0};
                    r_aux <= r_aux >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_result    = r_div ? r_quo : r_aux[30:0];

endmodule

FILE: hw/rtl/householder_qr_decompose_core.sv
// After the last element, Q is set to identity; step i of n-1 (c = n-i) takes two
// norm passes, one pivot update, c quotients and four-phase multiply-accumulate on
// one shared 33x33 multiplier; then 2*n*n result items, one per cycle unless stalled.
// Throughput: one matrix at a time; no element is taken until the final R item has
// entered the output register.
// Reset (synchronous, active low) sets the size to 3 and restarts loading; stores kept.
module householder_qr_decompose_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,       // matrix_size
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,      // [31:0] element_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,      // [1:0] out_row, [3:2] out_col, [35:4] out_value
    output logic        o_m_axis_tuser,      // [0] which_matrix
    output logic        o_m_axis_tlast       // last_result
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_QINIT  = 4'd1;
    localparam logic [3:0] S_MAX    = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_RSTART = 4'd5;
    localparam logic [3:0] S_ROOT   = 4'd6;
    localparam logic [3:0] S_PIVOT  = 4'd7;
    localparam logic [3:0] S_DSTART = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_DOT    = 4'd10;
    localparam logic [3:0] S_APPLY  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0]         r_state;
    logic [2:0]         r_size;
    logic [1:0]         r_lr, r_lc;
    logic [3:0]         r_qi;
    logic [1:0]         r_step, r_z, r_line;
    logic               r_second, r_selq;
    logic [1:0]         r_ph;
    logic [51:0]        r_max;
    logic [4:0]         r_shift;
    logic [61:0]        r_sum;
    logic [30:0]        r_nrm;
    logic signed [65:0] r_prod, r_lo;
    logic signed [53:0] r_mu;
    logic signed [51:0] r_d;
    logic signed [47:0] r_work [16];
    logic signed [47:0] r_q    [16];
    logic signed [51:0] r_vec  [4];
    logic signed [31:0] r_u    [4];
    logic               r_om;
    logic [1:0]         r_or, r_oc;
    logic               r_ovalid;
    logic [39:0]        r_odata;
    logic               r_ouser, r_olast;

    logic [2:0]         size_n;
    logic [1:0]         nm1;
    logic [3:0]         rd_addr;
    logic signed [47:0] work_rd, q_rd, elem_rd;
    logic signed [51:0] x_src, p_op, norm;
    logic [51:0]        mag_cur;
    logic [29:0]        q30;
    logic [4:0]         shift_enc;
    logic signed [32:0] mul_a, mul_b;
    logic signed [83:0] mu_sum;
    logic signed [55:0] diff;
    logic               last_step, out_load, out_end;
    hqr_pkg::t_rd_cmd   rd_cmd;
    hqr_pkg::t_rd_stat  rd_stat;
    logic [30:0]        rd_res;

    assign size_n = (r_size < 3'd2) ? 3'd2 :
                    (r_size > 3'(hqr_pkg::MAX_SIZE)) ? 3'(hqr_pkg::MAX_SIZE) : r_size;
    assign nm1       = 2'(size_n - 3'd1);
    assign last_step = (r_step == nm1 - 2'd1);

    always_comb begin
        unique case (r_state)
            S_MAX:   rd_addr = {r_z, r_step};
            S_OUT:   rd_addr = {r_or, r_oc};
            default: rd_addr = r_selq ? {r_line, r_z} : {r_z, r_line};
        endcase
    end

    assign work_rd = r_work[rd_addr];
    assign q_rd    = r_q[rd_addr];
    assign elem_rd = r_selq ? q_rd : work_rd;

    assign x_src   = (r_state == S_MAX && !r_second) ? 52'(work_rd) : r_vec[r_z];
    assign mag_cur = x_src[51] ? 52'(-x_src) : 52'(x_src);
    assign q30     = 30'(mag_cur >> r_shift);
    assign norm    = 52'(r_nrm) << r_shift;

    // smallest shift bringing the largest magnitude below 2^30
    always_comb begin
        shift_enc = '0;
        for (int k = 30; k < 52; k++) begin
            if (r_max[k]) shift_enc = 5'(k - 29);
        end
    end

    assign p_op = (r_state == S_APPLY) ? r_d : 52'(elem_rd);

    always_comb begin
        if (r_state == S_SQ) begin
            mul_a = {3'b000, q30};
            mul_b = {3'b000, q30};
        end else begin
            mul_a = (r_ph == 2'd0) ? {7'b0, p_op[25:0]} : 33'($signed(p_op[51:26]));
            mul_b = 33'(r_u[r_z]);
        end
    end

    assign mu_sum = (84'(r_prod) <<< 26) + 84'(r_lo);
    assign diff   = 56'(elem_rd) - (56'(r_mu) <<< 1);

    assign rd_cmd.start  = (r_state == S_RSTART) || (r_state == S_DSTART);
    assign rd_cmd.is_div = (r_state == S_DSTART);

    hqr_rootdiv u_rootdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (rd_cmd),
        .i_opa    ((r_state == S_DSTART) ? 62'(q30) : r_sum),
        .i_opb    (r_nrm),
        .o_stat   (rd_stat),
        .o_result (rd_res)
    );

    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);
    assign out_end  = r_om && (r_or == nm1) && (r_oc == nm1);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_size   <= 3'd3;
            r_lr     <= '0;
            r_lc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
                r_lr   <= '0;
                r_lc   <= '0;
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_m_axis_tready) r_ovalid <= 1'b0;

            unique case (r_state) inside
                S_LOAD: begin
                    if (i_s_axis_tvalid && o_s_axis_tready) begin
                        r_work[{r_lr, r_lc}] <= 48'($signed(i_s_axis_tdata));
                        if (r_lc == nm1) begin
                            r_lc <= '0;
                            if (r_lr == nm1) begin
                                r_lr    <= '0;
                                r_qi    <= '0;
                                r_state <= S_QINIT;
                            end else begin
                                r_lr <= r_lr + 2'd1;
                            end
                        end else begin
                            r_lc <= r_lc + 2'd1;
                        end
                    end
                end
                S_QINIT: begin
                    r_q[r_qi] <= (r_qi[3:2] == r_qi[1:0]) ? (48'sd1 <<< hqr_pkg::FRAC_BITS)
                                                        : 48'sd0;
                    r_qi <= r_qi + 4'd1;
                    if (r_qi == 4'd15) begin
                        r_step   <= '0;
                        r_z      <= '0;
                        r_max    <= '0;
                        r_second <= 1'b0;
                        r_state  <= S_MAX;
                    end
                end
                S_MAX: begin
                    if (!r_second) r_vec[r_z] <= x_src;
                    if (mag_cur > r_max) r_max <= mag_cur;
                    if (r_z == nm1) r_state <= S_SHIFT;
                    else r_z <= r_z + 2'd1;
                end
                S_SHIFT: begin
                    r_shift <= shift_enc;
                    r_z     <= r_step;
                    r_sum   <= '0;
                    r_ph    <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph  <= 2'd0;
                        r_sum <= r_sum + r_prod[61:0];
                        if (r_z == nm1) begin
                            r_z     <= r_step;
                            r_state <= S_RSTART;
                        end else begin
                            r_z <= r_z + 2'd1;
                        end
                    end
                end
                S_RSTART: r_state <= S_ROOT;
                S_ROOT: begin
                    if (rd_stat.done) begin
                        r_nrm <= rd_res;
                        if (!r_second) begin
                            r_state <= S_PIVOT;
                        end else if (rd_res == '0) begin
                            // zero reflector: leave this step as identity
                            if (last_step) begin
                                r_om    <= 1'b0;
                                r_or    <= '0;
                                r_oc    <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_step   <= r_step + 2'd1;
                                r_z      <= r_step + 2'd1;
                                r_max    <= '0;
                                r_second <= 1'b0;
                                r_state  <= S_MAX;
                            end
                        end else begin
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_PIVOT: begin
                    r_vec[r_z] <= x_src[51] ? (x_src - norm) : (x_src + norm);
                    r_second   <= 1'b1;
                    r_max      <= '0;
                    r_state    <= S_MAX;
                end
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (rd_stat.done) begin
                        r_u[r_z] <= x_src[51] ? -32'(rd_res) : 32'(rd_res);
                        if (r_z == nm1) begin
                            r_z     <= r_step;
                            r_line  <= '0;
                            r_selq  <= 1'b0;
                            r_d     <= '0;
                            r_ph    <= '0;
                            r_state <= S_DOT;
                        end else begin
                            r_z     <= r_z + 2'd1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_DOT, S_APPLY: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd1) r_lo <= r_prod;
                    if (r_ph == 2'd2) r_mu <= mu_sum[83:30];
                    if (r_ph == 2'd3) begin
                        if (r_state == S_DOT) begin
                            r_d <= r_d + r_mu[51:0];
                            if (r_z == nm1) begin
                                r_z     <= r_step;
                                r_state <= S_APPLY;
                            end else begin
                                r_z <= r_z + 2'd1;
                            end
                        end else begin
                            if (r_selq) r_q[rd_addr] <= hqr_pkg::sat48(diff);
                            else r_work[rd_addr] <= hqr_pkg::sat48(diff);
                            if (r_z == nm1) begin
                                r_d <= '0;
                                if (r_line != nm1) begin
                                    r_line  <= r_line + 2'd1;
                                    r_z     <= r_step;
                                    r_state <= S_DOT;
                                end else if (!r_selq) begin
                                    r_line  <= '0;
                                    r_selq  <= 1'b1;
                                    r_z     <= r_step;
                                    r_state <= S_DOT;
                                end else if (last_step) begin
                                    r_om    <= 1'b0;
                                    r_or    <= '0;
                                    r_oc    <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_step   <= r_step + 2'd1;
                                    r_z      <= r_step + 2'd1;
                                    r_max    <= '0;
                                    r_second <= 1'b0;
                                    r_state  <= S_MAX;
                                end
                            end else begin
                                r_z <= r_z + 2'd1;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_odata  <= {4'b0000,
                                     hqr_pkg::sat32(r_om ? work_rd : q_rd),
                                     r_oc, r_or};
                        r_ouser  <= r_om;
                        r_olast  <= out_end;
                        if (out_end) begin
                            r_state <= S_LOAD;
                        end else if (r_oc == nm1) begin
                            r_oc <= '0;
                            if (r_or == nm1) begin
                                r_or <= '0;
                                r_om <= 1'b1;
                            end else begin
                                r_or <= r_or + 2'd1;
                            end
                        end else begin
                            r_oc <= r_oc + 2'd1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // hold off an element while the size is being written
    assign o_s_axis_tready = (r_state == S_LOAD) && !i_cfg_wr_en;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule

FILE: hw/rtl/hqr_checker.sv
// Port-level checks for the QR decomposition core, bound to the top level.
module hqr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // hold a stalled result item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result item changed");

    a_last_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            o_m_axis_tuser && (o_m_axis_tdata[1:0] == o_m_axis_tdata[3:2]))
        else $error("final item not on the diagonal of R");

    // while Q is still going out, no element is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> !o_s_axis_tready)
        else $error("input taken while results pending");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[39:36] == 4'b0000))
        else $error("padding bits set");

endmodule

bind householder_qr_decompose_core hqr_checker u_hqr_checker (.*);
